>>> rtl/btmh_pkg.sv
// Shared types, constants and the byte table of the bit set multiply-xor hash.
package btmh_pkg;

  localparam logic [63:0] HASH_SEED   = 64'hBB40E64DA205B064;
  localparam logic [63:0] TABLE_START = 64'h544B2FBACAAF1684;
  localparam logic [63:0] HASH_MUL    = 64'd7664345821815920749;
  localparam int unsigned MIX_ROUNDS  = 31;
  localparam int unsigned TABLE_SIZE  = 256;

  typedef logic [63:0] byte_table_t [TABLE_SIZE];

  // Evaluated at elaboration only; the result is a constant table.
  function automatic byte_table_t build_byte_table();
    byte_table_t tbl;
    logic [63:0] x;
    x = TABLE_START;
    for (int j = 0; j < TABLE_SIZE; j++) begin
      for (int r = 0; r < MIX_ROUNDS; r++) begin
        x = x ^ (x >> 7);
        x = x ^ (x << 11);
        x = x ^ (x >> 10);
      end
      tbl[j] = x;
    end
    return tbl;
  endfunction

  localparam byte_table_t BYTE_TABLE = build_byte_table();

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_LO,
    OP_MUL_CROSS_A,
    OP_MUL_CROSS_B,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic in_empty;
    logic in_last;
    logic last_byte;
    logic last_flag;
  } status_t;

endpackage

>>> rtl/btmh_datapath.sv
// Datapath: word masking, shared 32x32 multiplier, running hash and output register.
module btmh_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic [63:0]         data_word,
  input  logic [6:0]          valid_bits,
  input  logic                last_word,
  input  btmh_pkg::cmd_t      cmd,
  output btmh_pkg::status_t   status,
  output logic [63:0]         hash_value
);

  localparam logic [31:0] MUL_LO = btmh_pkg::HASH_MUL[31:0];
  localparam logic [31:0] MUL_HI = btmh_pkg::HASH_MUL[63:32];

  logic [63:0] run_hash;
  logic [63:0] word_sr;
  logic [63:0] acc;
  logic [2:0]  byte_idx;
  logic        last_flag;

  logic [63:0] word_mask;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] acc_sum;

  // Counts of 64 and above keep the whole word.
  always_comb begin
    if (valid_bits[6]) begin
      word_mask = '1;
    end else begin
      word_mask = (64'd1 << valid_bits[5:0]) - 64'd1;
    end
  end

  always_comb begin
    case (cmd.op)
      btmh_pkg::OP_MUL_CROSS_A: begin
        mul_a = run_hash[31:0];
        mul_b = MUL_HI;
      end
      btmh_pkg::OP_MUL_CROSS_B: begin
        mul_a = run_hash[63:32];
        mul_b = MUL_LO;
      end
      default: begin
        mul_a = run_hash[31:0];
        mul_b = MUL_LO;
      end
    endcase
  end

  assign prod    = {32'd0, mul_a} * {32'd0, mul_b};
  assign acc_sum = acc + {prod[31:0], 32'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      run_hash  <= btmh_pkg::HASH_SEED;
      byte_idx  <= '0;
      last_flag <= 1'b0;
    end else begin
      case (cmd.op)
        btmh_pkg::OP_LOAD: begin
          byte_idx  <= '0;
          last_flag <= last_word;
        end
        btmh_pkg::OP_MUL_CROSS_B: begin
          run_hash <= acc_sum ^ btmh_pkg::BYTE_TABLE[word_sr[7:0]];
          byte_idx <= byte_idx + 3'd1;
        end
        btmh_pkg::OP_EMIT: begin
          run_hash <= btmh_pkg::HASH_SEED;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      btmh_pkg::OP_LOAD:        word_sr    <= data_word & word_mask;
      btmh_pkg::OP_MUL_LO:      acc        <= prod;
      btmh_pkg::OP_MUL_CROSS_A: acc        <= acc_sum;
      btmh_pkg::OP_MUL_CROSS_B: word_sr    <= {8'd0, word_sr[63:8]};
      btmh_pkg::OP_EMIT:        hash_value <= run_hash;
      default: begin
      end
    endcase
  end

  assign status.in_empty  = (valid_bits == 7'd0);
  assign status.in_last   = last_word;
  assign status.last_byte = (byte_idx == 3'd7);
  assign status.last_flag = last_flag;

endmodule

>>> rtl/btmh_ctrl.sv
// Controller: sequences load, three multiplier passes per byte, and emit.
module btmh_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               word_valid,
  output logic               word_stall,
  output logic               hash_valid,
  input  logic               hash_stall,
  input  btmh_pkg::status_t  status,
  output btmh_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,
    S_CROSS_A,
    S_CROSS_B,
    S_EMIT
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free   = !hash_valid || !hash_stall;
  assign word_stall = (state != S_IDLE);

  always_comb begin
    case (state)
      S_IDLE:    cmd.op = word_valid ? btmh_pkg::OP_LOAD : btmh_pkg::OP_NONE;
      S_MUL_LO:  cmd.op = btmh_pkg::OP_MUL_LO;
      S_CROSS_A: cmd.op = btmh_pkg::OP_MUL_CROSS_A;
      S_CROSS_B: cmd.op = btmh_pkg::OP_MUL_CROSS_B;
      S_EMIT:    cmd.op = out_free ? btmh_pkg::OP_EMIT : btmh_pkg::OP_NONE;
      default:   cmd.op = btmh_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      hash_valid <= 1'b0;
    end else begin
      // Drop the result once taken; an emit below overrides.
      if (hash_valid && !hash_stall) begin
        hash_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (word_valid) begin
            if (!status.in_empty) begin
              state <= S_MUL_LO;
            end else if (status.in_last) begin
              state <= S_EMIT;
            end
          end
        end
        S_MUL_LO:  state <= S_CROSS_A;
        S_CROSS_A: state <= S_CROSS_B;
        S_CROSS_B: begin
          if (!status.last_byte) begin
            state <= S_MUL_LO;
          end else if (status.last_flag) begin
            state <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            hash_valid <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/bitset_table_multiply_hash_top.sv
// Top level of the bit set multiply-xor hash: controller plus datapath.
//
//  channel | signals                                | transaction
//  --------+----------------------------------------+---------------------------
//  word    | word_valid, word_stall, data_word,     | one 64-bit word of the set
//          | valid_bits, last_word                  |
//  hash    | hash_valid, hash_stall, hash_value     | hash of a finished set
//
// A word transaction is taken when word_valid is high and word_stall is low. A word
// with a nonzero valid count then folds its eight bytes, each in three passes through
// the one shared 32x32 multiplier (low product, two cross products, then add and
// table xor); a word with zero valid bits is done once it is accepted. A last word
// adds an emit step that loads the output register once the output is free.
// Synchronous reset reseeds the running hash and clears hash_valid.
// word_stall is high while bytes fold or a result waits to be emitted; a new
// word is taken while an earlier hash still sits unclaimed under hash_stall.
module bitset_table_multiply_hash_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        word_valid,
  output logic        word_stall,
  input  logic [63:0] data_word,
  input  logic [6:0]  valid_bits,
  input  logic        last_word,
  output logic        hash_valid,
  input  logic        hash_stall,
  output logic [63:0] hash_value
);

  btmh_pkg::cmd_t    cmd;
  btmh_pkg::status_t status;

  // Sequence load, per-byte multiplier passes and emit.
  btmh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .word_valid (word_valid),
    .word_stall (word_stall),
    .hash_valid (hash_valid),
    .hash_stall (hash_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // Hold the masked word, running hash and output register.
  btmh_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .data_word  (data_word),
    .valid_bits (valid_bits),
    .last_word  (last_word),
    .cmd        (cmd),
    .status     (status),
    .hash_value (hash_value)
  );

  // A nonempty word keeps the input stalled on the next cycle while it folds.
  a_fold_stalls: assert property (@(posedge clk) disable iff (rst)
    (word_valid && !word_stall && !status.in_empty) |=> word_stall)
    else $error("input not stalled while a word folds");

  // A new result appears only through an emit command.
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(hash_valid) |-> $past(cmd.op == btmh_pkg::OP_EMIT))
    else $error("result raised without an emit");

  // Never overwrite a result that is still waiting to be taken.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == btmh_pkg::OP_EMIT) |-> (!hash_valid || !hash_stall))
    else $error("emit overwrote a pending result");

endmodule
